[src/spc_pkg.sv]
package spc_pkg;

  localparam int unsigned STEP_W     = 10;
  localparam int unsigned MAX_STEPS  = 1 << STEP_W;
  localparam int unsigned WAYS_W     = 63;
  localparam int unsigned HOPS_W     = 11;
  localparam int unsigned BASE_W     = 11;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CNT_W-1:0]  MAX_JUMPS  = 4'd11;
  localparam logic [BASE_W-1:0] BASE_MIN   = 11'd2;
  localparam logic [BASE_W-1:0] BASE_RST   = 11'd2;
  localparam logic [CNT_W-1:0]  COUNT_RST  = 4'd11;
  // powers beyond the staircase park here and never match a step
  localparam logic [BASE_W-1:0] JUMP_LIMIT = 11'(MAX_STEPS + 1);

  localparam logic [WAYS_W-1:0] WAYS_CEIL = {WAYS_W{1'b1}};
  localparam logic [HOPS_W-1:0] HOPS_CEIL = {HOPS_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'd1;

  typedef struct packed {
    logic              usable;
    logic [HOPS_W-1:0] hops;
    logic [WAYS_W-1:0] ways;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic store;
  } cmd_t;

  typedef struct packed {
    logic             skip;
    logic [CNT_W-1:0] count;
  } status_t;

endpackage

[src/spc_if.sv]
interface spc_step_if;
  logic valid;
  logic ready;
  logic start_new;
  logic broken;
  logic last_step;

  modport source (output valid, output start_new, output broken, output last_step,
                  input ready);
  modport sink (input valid, input start_new, input broken, input last_step,
                output ready);
endinterface

interface spc_result_if;
  import spc_pkg::*;
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step_index;
  logic [WAYS_W-1:0] ways;
  logic [HOPS_W-1:0] min_hops;
  logic              reachable;
  logic              saturated;
  logic              is_top;

  modport source (output valid, output step_index, output ways, output min_hops,
                  output reachable, output saturated, output is_top, input ready);
  modport sink (input valid, input step_index, input ways, input min_hops,
                input reachable, input saturated, input is_top, output ready);
endinterface

[src/spc_datapath.sv]
module spc_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           start_new_i,
  input  logic                           broken_i,
  input  logic                           last_step_i,
  input  spc_pkg::cmd_t                  cmd_i,
  output spc_pkg::status_t               status_o,
  output logic [spc_pkg::STEP_W-1:0]     step_index_o,
  output logic [spc_pkg::WAYS_W-1:0]     ways_o,
  output logic [spc_pkg::HOPS_W-1:0]     min_hops_o,
  output logic                           reachable_o,
  output logic                           saturated_o,
  output logic                           is_top_o
);
  import spc_pkg::*;

  entry_t            mem_q [MAX_STEPS];
  entry_t            rd_q;

  logic [BASE_W-1:0] base_q;
  logic [CNT_W-1:0]  count_q;
  logic [STEP_W-1:0] pos_q, idx_q, idx_d;
  logic              top_q;
  logic [BASE_W-1:0] pw_q, pw_d, base_eff;
  logic [2*BASE_W-1:0] prod;
  logic              pend_ground_q, pend_mem_q;
  logic              hit_ground, hit_mem;
  logic [STEP_W-1:0] src_addr;
  logic [WAYS_W-1:0] ways_q, ways_d, addend;
  logic [WAYS_W:0]   sum;
  logic [HOPS_W-1:0] hops_q, hops_d, cand;
  logic              take;
  logic [CNT_W-1:0]  count_eff;

  assign base_eff  = (base_q < BASE_MIN) ? BASE_MIN : base_q;
  assign count_eff = (count_q > MAX_JUMPS) ? MAX_JUMPS : count_q;
  assign status_o  = '{skip: broken_i || (count_eff == '0), count: count_eff};

  assign idx_d = start_new_i ? '0 : pos_q;

  // next power of the base, clamped past the staircase
  assign prod = {{BASE_W{1'b0}}, pw_q} * {{BASE_W{1'b0}}, base_eff};
  assign pw_d = (prod > {{BASE_W{1'b0}}, JUMP_LIMIT}) ? JUMP_LIMIT : prod[BASE_W-1:0];

  assign hit_ground = (pw_q == ({1'b0, idx_q} + 1'b1));
  assign hit_mem    = (pw_q <= {1'b0, idx_q});
  assign src_addr   = idx_q - pw_q[STEP_W-1:0];

  // fold the request issued in the previous cycle
  assign take   = pend_ground_q || (pend_mem_q && rd_q.usable);
  assign addend = pend_ground_q ? WAYS_W'(1) : rd_q.ways;
  assign sum    = {1'b0, ways_q} + {1'b0, addend};
  assign cand   = pend_ground_q ? HOPS_W'(1) :
                  (rd_q.hops == HOPS_CEIL) ? HOPS_CEIL : rd_q.hops + 1'b1;

  always_comb begin
    ways_d = ways_q;
    hops_d = hops_q;
    if (take) begin
      ways_d = sum[WAYS_W] ? WAYS_CEIL : sum[WAYS_W-1:0];
      if (hops_q == '0 || cand < hops_q) begin
        hops_d = cand;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q        <= BASE_RST;
      count_q       <= COUNT_RST;
      pos_q         <= '0;
      pend_ground_q <= 1'b0;
      pend_mem_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BASE:  base_q  <= cfg_data_i[BASE_W-1:0];
          CFG_COUNT: count_q <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        pos_q <= idx_d + 1'b1;
      end
      pend_ground_q <= cmd_i.issue && hit_ground;
      pend_mem_q    <= cmd_i.issue && !hit_ground && hit_mem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q  <= idx_d;
      top_q  <= last_step_i;
      pw_q   <= BASE_W'(1);
      ways_q <= '0;
      hops_q <= '0;
    end else begin
      ways_q <= ways_d;
      hops_q <= hops_d;
      if (cmd_i.issue) begin
        pw_q <= pw_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[src_addr];
    if (cmd_i.store) begin
      mem_q[idx_q] <= '{usable: (ways_q != '0), hops: hops_q, ways: ways_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      step_index_o <= idx_q;
      ways_o       <= ways_q;
      min_hops_o   <= hops_q;
      reachable_o  <= (ways_q != '0);
      saturated_o  <= (ways_q == WAYS_CEIL);
      is_top_o     <= top_q;
    end
  end

endmodule

[src/spc_ctrl.sv]
module spc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  spc_pkg::status_t status_i,
  output spc_pkg::cmd_t    cmd_o
);
  import spc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_STORE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] jump_q;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o = '{accept: in_valid_i && in_ready_o,
                   issue:  (state_q == ST_RUN),
                   store:  (state_q == ST_STORE) && out_free};

  // a stored result is valid until taken
  assign out_valid_d = cmd_o.store || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      jump_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            jump_q  <= '0;
            state_q <= status_i.skip ? ST_STORE : ST_RUN;
          end
        end
        ST_RUN: begin
          jump_q <= jump_q + 1'b1;
          if (jump_q == status_i.count - 1'b1) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: state_q <= ST_STORE;
        ST_STORE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/staircase_path_counter.sv]
// Staircase path counter: each step request carries start/broken/top flags and
// yields one result with the step index, the saturating count of jump sequences
// that reach it and the fewest jumps. Jumps are powers of jump_base, the count of
// them set by jump_count. One step is worked at a time: the idle state takes the
// request, the single read port of the per-step memory serves one jump length per
// cycle in run, drain folds the last read and store, once the result register is
// free, writes the memory and loads it; a broken step or a count of zero goes
// straight to store. A finished result may wait in its register while the next
// step is taken. Write configuration only while no step is in flight.
module staircase_path_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  spc_step_if.sink                       step_i,
  spc_result_if.source                   result_o
);
  import spc_pkg::*;

  cmd_t    cmd;
  status_t status;

  spc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (step_i.valid),
    .in_ready_o  (step_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  spc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start_new_i  (step_i.start_new),
    .broken_i     (step_i.broken),
    .last_step_i  (step_i.last_step),
    .cmd_i        (cmd),
    .status_o     (status),
    .step_index_o (result_o.step_index),
    .ways_o       (result_o.ways),
    .min_hops_o   (result_o.min_hops),
    .reachable_o  (result_o.reachable),
    .saturated_o  (result_o.saturated),
    .is_top_o     (result_o.is_top)
  );

  // never overwrite a result that has not been taken
  a_store_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |-> (!result_o.valid || result_o.ready))
    else $error("result register overwritten");

  // one step in flight at a time
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> !step_i.ready)
    else $error("step taken while busy");

  // a new result only appears after a store
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(cmd.store))
    else $error("result valid without store");

  // every store leaves a valid result in the result register
  a_store_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |=> result_o.valid)
    else $error("store lost");

endmodule
